[design/mrtu_pkg.sv]
// ----------------------------------------------------------------------------
// mrtu_pkg
// Shared types, codes, the CRC-16/MODBUS byte step and the power-up register
// table of the Modbus RTU register responder.
// ----------------------------------------------------------------------------
`default_nettype none
package mrtu_pkg;

  localparam logic [7:0]  FN_READ_HOLDING = 8'h03;
  localparam logic [7:0]  FN_WRITE_SINGLE = 8'h06;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;
  localparam logic [7:0]  REQ_LEN         = 8'd8;
  localparam logic [7:0]  HEAD_LEN        = 8'd6;
  localparam int          IDX_W           = 6;
  localparam int          INIT_LEN        = 25;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SEND
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic check;
    logic load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic resp_ok;
    logic last;
    logic out_busy;
  } sts_t;

  // one CRC-16/MODBUS byte update, eight reflected shift steps
  function automatic logic [15:0] crc_step(input logic [15:0] crc_in,
                                           input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // power-up contents of the holding registers
  function automatic logic [15:0] init_word(input int i);
    logic [15:0] w;
    w = 16'h0000;
    if ((i >= 4 && i <= 8) || i == 22) begin
      w = 16'hFFFF;
    end else if (i == 9) begin
      w = 16'h0001;
    end
    return w;
  endfunction

endpackage
`default_nettype wire

[design/modbus_rtu_slave_register_responder_core.sv]
// ----------------------------------------------------------------------------
// modbus_rtu_slave_register_responder_core
// Modbus RTU slave for Read Holding Registers and Write Single Register.
// ----------------------------------------------------------------------------
// Request bytes are taken one per cycle while idle; a frame end leads to the
// frame check, and a frame that passes it gets a response streamed one byte
// per cycle out of the output register while the sink does not stall
// (2*N+5 bytes for a read of N words, 8 for a write). The next request byte
// is taken once the last response byte is in the output register. The CRC
// byte step is combinational; the register file reads one address per cycle.
`default_nettype none
module modbus_rtu_slave_register_responder_core
  import mrtu_pkg::*;
#(
  parameter int REG_COUNT      = 32,
  parameter int MAX_READ_WORDS = 29
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       in_frame_end,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_tx_byte,
  output logic            out_tx_last,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_slave_address
);

  cmd_t cmd;
  sts_t sts;

  // configuration is always taken
  assign cfg_ready = 1'b1;

  mrtu_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_frame_end (in_frame_end),
    .in_stall     (in_stall),
    .out_stall    (out_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  mrtu_datapath #(
    .REG_COUNT      (REG_COUNT),
    .MAX_READ_WORDS (MAX_READ_WORDS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .rx_byte   (in_rx_byte),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_slave_address),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_byte  (out_tx_byte),
    .out_last  (out_tx_last)
  );

endmodule
`default_nettype wire

[design/mrtu_ctrl.sv]
// ----------------------------------------------------------------------------
// mrtu_ctrl
// Sequencer: collects request bytes, triggers the frame check and paces the
// response bytes into the output register.
// ----------------------------------------------------------------------------
`default_nettype none
module mrtu_ctrl
  import mrtu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  input  wire logic in_frame_end,
  output logic      in_stall,
  input  wire logic out_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state_r, state_nxt;

  // hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_frame_end) begin
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = sts.resp_ok ? ST_SEND : ST_IDLE;
      end
      ST_SEND: begin
        if (!sts.out_busy || !out_stall) begin
          cmd.load = 1'b1;
          if (sts.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[design/mrtu_datapath.sv]
// ----------------------------------------------------------------------------
// mrtu_datapath
// Frame head, byte count, receive and transmit CRC, holding registers,
// response byte selection and the output register.
// ----------------------------------------------------------------------------
`default_nettype none
module mrtu_datapath
  import mrtu_pkg::*;
#(
  parameter int REG_COUNT      = 32,
  parameter int MAX_READ_WORDS = 29
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cmd_t       cmd,
  output sts_t            sts,
  input  wire logic [7:0] rx_byte,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_data,
  input  wire logic       out_stall,
  output logic            out_valid,
  output logic [7:0]      out_byte,
  output logic            out_last
);

  localparam int PW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  logic [7:0]       slave_r;
  logic [7:0]       head_r [HEAD_LEN];
  logic [7:0]       count_r;
  logic [15:0]      rx_crc_r;
  logic [15:0]      tx_crc_r;
  logic [15:0]      regs_r [REG_COUNT];
  logic             fn3_r;
  logic [IDX_W-1:0] len_r;
  logic [IDX_W-1:0] idx_r;
  logic [PW-1:0]    ptr_r;
  logic             half_r;
  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             out_last_r;

  logic [15:0] addr, val;
  logic [16:0] span;
  logic        is_rd, is_wr, base_ok, rd_ok, wr_ok;
  logic [7:0]  body_byte;
  logic [15:0] word;

  assign addr  = {head_r[2], head_r[3]};
  assign val   = {head_r[4], head_r[5]};
  assign span  = {1'b0, addr} + {1'b0, val};
  assign is_rd = head_r[1] == FN_READ_HOLDING;
  assign is_wr = head_r[1] == FN_WRITE_SINGLE;

  // frame checks in order of the protocol rules
  assign base_ok = (rx_crc_r == 16'h0000) && (head_r[0] != 8'h00) &&
                   (head_r[0] == slave_r) && (count_r == REQ_LEN);
  assign rd_ok   = is_rd && (val != 16'h0000) &&
                   (val <= 16'(MAX_READ_WORDS)) && (span <= 17'(REG_COUNT));
  assign wr_ok   = is_wr && (addr < 16'(REG_COUNT));

  assign sts.resp_ok  = base_ok && (rd_ok || wr_ok);
  assign sts.last     = idx_r == len_r + IDX_W'(1);
  assign sts.out_busy = out_valid_r;

  // pick the next response byte
  assign word = regs_r[ptr_r];
  always_comb begin
    priority if (fn3_r && idx_r >= IDX_W'(3)) begin
      body_byte = half_r ? word[7:0] : word[15:8];
    end else if (fn3_r && idx_r == IDX_W'(2)) begin
      body_byte = {val[6:0], 1'b0};
    end else begin
      body_byte = head_r[idx_r[2:0]];
    end
  end

  // station address register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_r <= 8'd4;
    end else if (cfg_we) begin
      slave_r <= cfg_data;
    end
  end

  // collect request bytes, restart at frame check
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      rx_crc_r <= CRC_INIT;
    end else if (cmd.accept) begin
      if (count_r != 8'hFF) begin
        count_r <= count_r + 8'd1;
      end
      rx_crc_r <= crc_step(rx_crc_r, rx_byte);
    end else if (cmd.check) begin
      count_r  <= '0;
      rx_crc_r <= CRC_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && count_r < HEAD_LEN) begin
      head_r[count_r[2:0]] <= rx_byte;
    end
  end

  // holding registers: power-up table, single register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        regs_r[i] <= (i < INIT_LEN) ? init_word(i) : 16'h0000;
      end
    end else if (cmd.check && base_ok && wr_ok) begin
      regs_r[addr[PW-1:0]] <= val;
    end
  end

  // response sequencing state
  always_ff @(posedge clk) begin
    if (cmd.check) begin
      fn3_r    <= is_rd;
      len_r    <= is_rd ? IDX_W'({val[5:0], 1'b0} + 7'd3) : IDX_W'(HEAD_LEN);
      idx_r    <= '0;
      ptr_r    <= addr[PW-1:0];
      half_r   <= 1'b0;
      tx_crc_r <= CRC_INIT;
    end else if (cmd.load) begin
      idx_r <= idx_r + IDX_W'(1);
      if (idx_r < len_r) begin
        tx_crc_r <= crc_step(tx_crc_r, body_byte);
        if (fn3_r && idx_r >= IDX_W'(3)) begin
          half_r <= ~half_r;
          if (half_r) begin
            ptr_r <= ptr_r + PW'(1);
          end
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (idx_r < len_r) begin
        out_byte_r <= body_byte;
      end else if (idx_r == len_r) begin
        out_byte_r <= tx_crc_r[7:0];
      end else begin
        out_byte_r <= tx_crc_r[15:8];
      end
      out_last_r <= sts.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule
`default_nettype wire
